// ===== sv/mkpq_pkg.sv =====
// Package for the min-key priority queue: word types, command codes and
// the command/status bundles between controller and datapath.
// No dependencies.
package mkpq_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 32;

  // Operation codes of the input word
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic             now_empty;
  } out_word_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic cap_en;    // capture the accepted input word
    logic ins_en;    // append captured entry unless full, set result
    logic fail_en;   // result is a failed remove
    logic idx_clr;   // start scan at entry 0
    logic rd_en;     // read entry at index, advance index
    logic cmp_en;    // returning read data feeds the minimum search
    logic pick_en;   // latch minimum as result, index to the slot after it
    logic sh_en;     // returning read data moves down one slot
    logic cnt_dec;   // one entry fewer
    logic out_load;  // load the output register
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic op_remove; // captured command is a remove
    logic cnt_zero;  // queue holds no entries
    logic rd_more;   // index below entry count
    logic rd_pend;   // a read returns data this cycle
    logic out_busy;  // output register holds a word not yet taken
  } sts_t;

endpackage

// ===== sv/mkpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mkpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mkpq_datapath.sv =====
// Datapath of the min-key priority queue: entry RAM, count, scan index,
// minimum tracking, result and output registers.
// Depends on mkpq_pkg and mkpq_ram.
module mkpq_datapath #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mkpq_pkg::ctl_t    ctl_i,
  output mkpq_pkg::sts_t    sts_o,
  input  mkpq_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mkpq_pkg::out_word_t out_word_o
);
  import mkpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int unsigned EW = KEY_W + PW;

  in_word_t         cap_q;
  logic [CW-1:0]    cnt_q, idx_q;
  logic             rd_pend_q;
  logic [AW-1:0]    ridx_q, best_idx_q;
  logic [KEY_W-1:0] best_key_q, res_key_q;
  logic [PW-1:0]    best_pay_q, res_pay_q;
  logic             res_status_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic             full;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [PW-1:0]    rd_pay;
  logic             take_min;

  assign full   = (cnt_q == CW'(CAPACITY));
  assign rd_key = ram_rdata[EW-1:PW];
  assign rd_pay = ram_rdata[PW-1:0];

  // Write port: append on insert, move one slot down during compaction
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = {cap_q.key, cap_q.payload[PW-1:0]};
    if (ctl_i.ins_en) begin
      ram_we = !full;
    end else if (ctl_i.sh_en && rd_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = ridx_q - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  mkpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Strict less-than keeps the earliest entry on equal keys
  assign take_min = ctl_i.cmp_en && rd_pend_q &&
                    ((ridx_q == '0) || (rd_key < best_key_q));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= ctl_i.rd_en;
      if (ctl_i.ins_en && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      priority if (ctl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctl_i.pick_en) begin
        idx_q <= CW'(best_idx_q) + CW'(1);
      end else if (ctl_i.rd_en) begin
        idx_q <= idx_q + CW'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_en) begin
      cap_q <= in_word_i;
    end
    if (ctl_i.rd_en) begin
      ridx_q <= idx_q[AW-1:0];
    end
    if (take_min) begin
      best_idx_q <= ridx_q;
      best_key_q <= rd_key;
      best_pay_q <= rd_pay;
    end
    priority if (ctl_i.ins_en) begin
      res_status_q <= !full;
      res_key_q    <= '0;
      res_pay_q    <= '0;
    end else if (ctl_i.fail_en) begin
      res_status_q <= 1'b0;
      res_key_q    <= '0;
      res_pay_q    <= '0;
    end else if (ctl_i.pick_en) begin
      res_status_q <= 1'b1;
      res_key_q    <= best_key_q;
      res_pay_q    <= best_pay_q;
    end
    if (ctl_i.out_load) begin
      out_q.status      <= res_status_q;
      out_q.out_key     <= res_key_q;
      out_q.out_payload <= PAY_W'(res_pay_q);
      out_q.now_empty   <= (cnt_q == '0);
    end
  end

  assign sts_o.op_remove = (cap_q.cmd == CMD_REMOVE);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.rd_more   = (idx_q != cnt_q);
  assign sts_o.rd_pend   = rd_pend_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.ins_en && full) |=> (cnt_q == CW'(CAPACITY)))
    else $error("insert into full queue changed count");

  a_shift_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.sh_en && rd_pend_q) |-> (ridx_q != '0) && (CW'(ridx_q) < cnt_q))
    else $error("compaction write outside held entries");

  a_out_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("output word overwritten before taken");

endmodule

// ===== sv/mkpq_ctrl.sv =====
// Controller of the min-key priority queue: sequences insert, minimum scan
// and compaction. Depends on mkpq_pkg.
module mkpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mkpq_pkg::sts_t sts_i,
  output mkpq_pkg::ctl_t ctl_o
);
  import mkpq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_PICK  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.cap_en = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (!sts_i.op_remove) begin
          ctl_o.ins_en = 1'b1;
          state_d      = S_DONE;
        end else if (sts_i.cnt_zero) begin
          ctl_o.fail_en = 1'b1;
          state_d       = S_DONE;
        end else begin
          ctl_o.idx_clr = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.cmp_en = 1'b1;
        ctl_o.rd_en  = sts_i.rd_more;
        if (!sts_i.rd_more && !sts_i.rd_pend) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        ctl_o.pick_en = 1'b1;
        state_d       = S_SHIFT;
      end
      S_SHIFT: begin
        ctl_o.sh_en = 1'b1;
        ctl_o.rd_en = sts_i.rd_more;
        if (!sts_i.rd_more && !sts_i.rd_pend) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_scan_exits_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> !sts_i.rd_pend)
    else $error("minimum latched with a read still in flight");

endmodule

// ===== sv/min_key_priority_queue.sv =====
// Top level of the min-key priority queue: controller plus datapath.
// Depends on mkpq_pkg, mkpq_ctrl, mkpq_datapath (and mkpq_ram below it).
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_word_i): one command word,
//     cmd insert appends (key, payload), cmd remove takes the entry with the
//     smallest key, earliest inserted first on equal keys.
//   out channel (out_valid_o / out_ready_i / out_word_o): exactly one result
//     word per command, in command order: status, removed key and payload
//     (zero unless a remove succeeded), and whether the queue is now empty.
// Sequence: an insert or a failed remove goes from the execute state
// straight to the done state, which loads the result once the output
// register is free. A remove with n entries held goes through scan, pick
// and shift; the entry RAM has one read port and is read once per cycle,
// first over all n entries to find the minimum, then over the entries
// behind it to close the gap.
// A new command is accepted in the cycle after the result is loaded, never
// while one is still running.
// Reset empties the queue; the entry RAM is not cleared, since only slots
// below the entry count are ever read. When the receiver stalls, the result
// waits in the output register; the next command is still accepted and runs,
// and its result waits until the older word is taken.
module min_key_priority_queue #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mkpq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mkpq_pkg::out_word_t out_word_o
);
  import mkpq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mkpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mkpq_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
